// ----- src/ffsa_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit segment allocator package
// Operation and status codes, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_MERGE   = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_FIT   = 2'd1,
        STAT_BAD_ADDR = 2'd2,
        STAT_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic    load_req;
        logic    init_wr;
        logic    rd_shift;
        logic    idx_inc;
        logic    load_found;
        logic    wr_exact;
        logic    wr_free;
        logic    k_load;
        logic    wr_shift;
        logic    k_dec;
        logic    wr_split_hi;
        logic    wr_split_lo;
        logic    merge_step;
        logic    merge_end;
        logic    res_load;
        logic    grant;
        t_status res_status;
    } t_cmd;

    typedef struct packed {
        logic size_zero;
        logic bad_addr;
        logic scan_end;
        logic fit;
        logic exact;
        logic full;
        logic match;
        logic shift_done;
        logic out_free;
    } t_sts;

endpackage

// ----- src/ffsa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ffsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// First-fit segment allocator controller
// Sequences the table scan, the shift that opens a slot for a split, the
// merge pass and the hand-over of each result.
// ----------------------------------------------------------------------------
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    output logic       o_in_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SPLIT_HI,
        S_SPLIT_LO,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_MERGE_END,
        S_FINISH
    } t_state;

    t_state  r_state, n_state;
    t_func   r_func, n_func;
    t_status r_status, n_status;
    logic    r_grant, n_grant;

    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_status = r_status;
        n_grant  = r_grant;
        o_cmd    = '0;
        o_cmd.res_status = r_status;
        o_cmd.grant      = r_grant;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_func   = t_func'(i_func);
                    n_status = STAT_OK;
                    n_grant  = 1'b0;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (r_func)
                    FUNC_ALLOC: begin
                        if (i_sts.size_zero) begin
                            n_status = STAT_NO_FIT;
                            n_state  = S_FINISH;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    FUNC_RELEASE: begin
                        if (i_sts.bad_addr) begin
                            n_status = STAT_BAD_ADDR;
                            n_state  = S_FINISH;
                        end else begin
                            n_state = S_SCAN_RD;
                        end
                    end
                    FUNC_MERGE: n_state = S_MERGE_RD;
                    default:    n_state = S_FINISH;
                endcase
            end
            S_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    n_status = (r_func == FUNC_ALLOC) ? STAT_NO_FIT : STAT_OK;
                    n_state  = S_FINISH;
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (r_func == FUNC_ALLOC) begin
                    if (i_sts.fit) begin
                        o_cmd.load_found = 1'b1;
                        if (i_sts.exact) begin
                            o_cmd.wr_exact = 1'b1;
                            n_grant = 1'b1;
                            n_state = S_FINISH;
                        end else if (i_sts.full) begin
                            n_status = STAT_FULL;
                            n_state  = S_FINISH;
                        end else begin
                            o_cmd.k_load = 1'b1;
                            n_state = S_SHIFT_RD;
                        end
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    if (i_sts.match) begin
                        o_cmd.wr_free = 1'b1;
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SHIFT_RD: begin
                o_cmd.rd_shift = 1'b1;
                n_state = i_sts.shift_done ? S_SPLIT_HI : S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.k_dec    = 1'b1;
                n_state = S_SHIFT_RD;
            end
            S_SPLIT_HI: begin
                o_cmd.wr_split_hi = 1'b1;
                n_state = S_SPLIT_LO;
            end
            S_SPLIT_LO: begin
                o_cmd.wr_split_lo = 1'b1;
                n_grant = 1'b1;
                n_state = S_FINISH;
            end
            S_MERGE_RD: begin
                n_state = i_sts.scan_end ? S_MERGE_END : S_MERGE_CHK;
            end
            S_MERGE_CHK: begin
                o_cmd.merge_step = 1'b1;
                o_cmd.idx_inc    = 1'b1;
                n_state = S_MERGE_RD;
            end
            S_MERGE_END: begin
                o_cmd.merge_end = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_func   <= FUNC_NONE;
            r_status <= STAT_OK;
            r_grant  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_func   <= n_func;
            r_status <= n_status;
            r_grant  <= n_grant;
        end
    end

endmodule

// ----- src/ffsa_dp.sv -----
// ----------------------------------------------------------------------------
// First-fit segment allocator datapath
// Holds the segment table memory, the pool size, the segment count, the scan
// and shift indexes and the result register.
// ----------------------------------------------------------------------------
module ffsa_dp
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDR_BITS    = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [ADDR_BITS:0]   i_cfg_wdata,
    input  logic [ADDR_BITS:0]   i_req_size,
    input  logic [ADDR_BITS-1:0] i_release_offset,
    input  logic                 i_out_ready,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output logic                 o_out_valid,
    output logic [ADDR_BITS-1:0] o_granted_offset,
    output logic [1:0]           o_status
);

    localparam int AB = ADDR_BITS;
    localparam int EW = 2 * AB + 2;
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAX_C    = CW'(MAX_SEGMENTS);
    localparam logic [AB:0]   POOL_MAX = {1'b1, {AB{1'b0}}};

    logic [AB:0]   r_pool;
    logic [CW-1:0] r_count, r_idx, r_k, r_wr, r_pos;
    logic [EW-1:0] r_ent, r_prev;
    logic [AB:0]   r_size;
    logic [AB-1:0] r_offset;
    logic          r_out_valid;
    logic [AB-1:0] r_granted;
    logic [1:0]    r_status;

    logic [EW-1:0] rd_data, wdata;
    logic [AW-1:0] waddr, raddr;
    logic          we;
    logic [AB:0]   cfg_pool;
    logic [AB-1:0] d_start, e_start;
    logic [AB:0]   d_len, e_len;
    logic          d_free, join_seg;
    logic [CW-1:0] wr_m1, k_m1, pos_p1;

    assign d_start = rd_data[EW-1 -: AB];
    assign d_len   = rd_data[AB+1:1];
    assign d_free  = rd_data[0];
    assign e_start = r_ent[EW-1 -: AB];
    assign e_len   = r_ent[AB+1:1];
    assign wr_m1   = r_wr - CW'(1);
    assign k_m1    = r_k - CW'(1);
    assign pos_p1  = r_pos + CW'(1);
    assign join_seg = (r_wr != '0) && r_prev[0] && d_free;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_pool = (AB + 1)'(1);
        end else if (i_cfg_wdata > POOL_MAX) begin
            cfg_pool = POOL_MAX;
        end else begin
            cfg_pool = i_cfg_wdata;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (i_cfg_we) begin
            we    = 1'b1;
            wdata = {{AB{1'b0}}, cfg_pool, 1'b1};
        end else if (i_cmd.init_wr) begin
            we    = 1'b1;
            wdata = {{AB{1'b0}}, r_pool, 1'b1};
        end else if (i_cmd.wr_exact || i_cmd.wr_free) begin
            we    = 1'b1;
            waddr = r_idx[AW-1:0];
            wdata = {d_start, d_len, i_cmd.wr_free};
        end else if (i_cmd.wr_shift) begin
            we    = 1'b1;
            waddr = r_k[AW-1:0];
            wdata = rd_data;
        end else if (i_cmd.wr_split_hi) begin
            we    = 1'b1;
            waddr = pos_p1[AW-1:0];
            wdata = {e_start + r_size[AB-1:0], e_len - r_size, 1'b1};
        end else if (i_cmd.wr_split_lo) begin
            we    = 1'b1;
            waddr = r_pos[AW-1:0];
            wdata = {e_start, r_size, 1'b0};
        end else if ((i_cmd.merge_step && !join_seg && r_wr != '0) || i_cmd.merge_end) begin
            we    = 1'b1;
            waddr = wr_m1[AW-1:0];
            wdata = r_prev;
        end
    end

    assign raddr = i_cmd.rd_shift ? k_m1[AW-1:0] : r_idx[AW-1:0];

    ffsa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    always_comb begin
        o_sts.size_zero  = (r_size == '0);
        o_sts.bad_addr   = ({1'b0, r_offset} >= r_pool);
        o_sts.scan_end   = (r_idx >= r_count);
        o_sts.fit        = d_free && (d_len >= r_size);
        o_sts.exact      = (d_len == r_size);
        o_sts.full       = (r_count == MAX_C);
        o_sts.match      = (d_start == r_offset);
        o_sts.shift_done = ({1'b0, r_k} <= ({1'b0, r_pos} + (CW + 1)'(1)));
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool      <= POOL_MAX;
            r_count     <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pool  <= cfg_pool;
                r_count <= CW'(1);
            end else if (i_cmd.init_wr) begin
                r_count <= CW'(1);
            end else if (i_cmd.wr_split_lo) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.merge_end) begin
                r_count <= r_wr;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_size   <= i_req_size;
            r_offset <= i_release_offset;
            r_idx    <= '0;
            r_wr     <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.load_found) begin
            r_ent <= rd_data;
            r_pos <= r_idx;
        end
        if (i_cmd.k_load) begin
            r_k <= r_count;
        end else if (i_cmd.k_dec) begin
            r_k <= k_m1;
        end
        if (i_cmd.merge_step) begin
            if (join_seg) begin
                r_prev[AB+1:1] <= r_prev[AB+1:1] + d_len;
            end else begin
                r_prev <= rd_data;
                r_wr   <= r_wr + CW'(1);
            end
        end
        if (i_cmd.res_load) begin
            r_status  <= i_cmd.res_status;
            r_granted <= i_cmd.grant ? e_start : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_granted_offset = r_granted;
    assign o_status         = r_status;

endmodule

// ----- src/first_fit_segment_allocator.sv -----
// ----------------------------------------------------------------------------
// First-fit segment allocator
// Keeps an ordered table of segments over a pool and serves allocate,
// release and merge requests, one result per request.
// ----------------------------------------------------------------------------
// Requests are served one at a time from a table held in a single RAM with
// one read and one write port. After reset the block writes the initial
// segment before it takes a request. An allocate or a release scans the
// table one segment at a time (read, then check); an allocate that splits a
// segment then moves every later entry up by one, with a read and a write
// for each entry. A merge visits every segment, with a read and a check for
// each. The scan and the shift together cover the table once. A result
// waits in an output register, and the next request is taken once it has
// been handed over to that register. Writing the pool size puts the table
// back to one free segment at once.
module first_fit_segment_allocator
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDR_BITS    = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [ADDR_BITS:0]   i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_func,
    input  logic [ADDR_BITS:0]   i_req_size,
    input  logic [ADDR_BITS-1:0] i_release_offset,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ADDR_BITS-1:0] o_granted_offset,
    output logic [1:0]           o_status
);

    t_cmd cmd;
    t_sts sts;

    ffsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffsa_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req_size       (i_req_size),
        .i_release_offset (i_release_offset),
        .i_out_ready      (i_out_ready),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_out_valid),
        .o_granted_offset (o_granted_offset),
        .o_status         (o_status)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while the previous one is still in work");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |=> o_out_valid)
        else $error("loaded result is not presented");

    a_one_table_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.init_wr, cmd.wr_exact, cmd.wr_free, cmd.wr_shift,
                  cmd.wr_split_hi, cmd.wr_split_lo, cmd.merge_end}))
        else $error("more than one table write requested in a cycle");
`endif

endmodule
